>>> src/vrrc_pkg.sv
// Package with the shared widths, codes and defaults of the versioned round-robin cache.
`default_nettype none

package vrrc_pkg;

  localparam int unsigned KeyBits         = 64;
  localparam int unsigned VersionBits     = 64;
  localparam int unsigned StatusBits      = 3;
  localparam int unsigned PayloadWordBits = 64;

  localparam int unsigned DefaultEntries     = 2048;
  localparam int unsigned DefaultPayloadBits = 64;

  // Command codes carried in the request cmd field.
  localparam logic CmdLookup = 1'b0;
  localparam logic CmdStore  = 1'b1;

  // A store with this status is dropped.
  localparam logic [StatusBits-1:0] StatusUnknown = '0;

endpackage : vrrc_pkg

`default_nettype wire

>>> src/vrrc_if.sv
// Request and response channel interfaces of the versioned round-robin cache.
`default_nettype none

interface vrrc_req_if;
  import vrrc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   cmd;
  logic [KeyBits-1:0]     key_hash;
  logic [VersionBits-1:0] version;
  logic [StatusBits-1:0]  status;
  logic [PayloadWordBits-1:0] payload;

  modport source (output valid, output cmd, output key_hash, output version,
                  output status, output payload, input ready);
  modport sink   (input valid, input cmd, input key_hash, input version,
                  input status, input payload, output ready);
endinterface : vrrc_req_if

interface vrrc_rsp_if;
  import vrrc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic [StatusBits-1:0]      hit_status;
  logic [PayloadWordBits-1:0] hit_payload;

  modport source (output valid, output hit, output hit_status, output hit_payload,
                  input ready);
  modport sink   (input valid, input hit, input hit_status, input hit_payload,
                  output ready);
endinterface : vrrc_rsp_if

`default_nettype wire

>>> src/versioned_round_robin_cache.sv
// Top level of the versioned round-robin cache: entry memory, slot pointer and scan sequencer.
`default_nettype none

// Channel  | Direction | Transaction
// ---------+-----------+---------------------------------------------------------
// req_i    | sink      | cmd, key_hash, version, status, payload (lookup or store)
// rsp_o    | source    | hit, hit_status, hit_payload (one per lookup, none per store)
//
// After reset the block sweeps the entry memory, clearing every
// valid mark, and accepts no transaction until the sweep is done.
// A store is written at the edge where it is accepted.
// A lookup reads one entry per cycle through the single memory read port, from slot 0
// upward; the first valid slot with the key ends it, else it ends after the last slot.
// The result waits in an output register; a stalled response holds the block only
// once the next lookup finishes.

module versioned_round_robin_cache
  import vrrc_pkg::*;
#(
  parameter int unsigned ENTRIES      = DefaultEntries,
  parameter int unsigned PAYLOAD_BITS = DefaultPayloadBits
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  vrrc_req_if.sink     req_i,
  vrrc_rsp_if.source   rsp_o
);

  localparam int unsigned IdxBits = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IdxBits-1:0] LastIdx = IdxBits'(ENTRIES - 1);

  // One memory word holds a whole entry, valid mark included.
  typedef struct packed {
    logic                    valid;
    logic [KeyBits-1:0]      key;
    logic [VersionBits-1:0]  version;
    logic [StatusBits-1:0]   status;
    logic [PAYLOAD_BITS-1:0] payload;
  } entry_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_e;

  // Entry memory with one write port and one registered read port.
  entry_t               mem [ENTRIES];
  entry_t               rdata_q;
  logic                 rd_en;
  logic [IdxBits-1:0]   rd_addr;
  logic                 wr_en;
  logic [IdxBits-1:0]   wr_addr;
  entry_t               wr_data;

  state_e               state_q, state_d;
  logic [IdxBits-1:0]   ptr_q, ptr_d;
  logic [IdxBits-1:0]   ptr_next;
  logic [IdxBits-1:0]   idx_q, idx_d;          // clear sweep and scan issue address
  logic                 issue_done_q, issue_done_d;
  logic                 chk_vld_q, chk_vld_d;  // rdata_q holds the entry at chk_addr_q
  logic [IdxBits-1:0]   chk_addr_q, chk_addr_d;
  logic                 chk_last_q, chk_last_d;
  logic [KeyBits-1:0]   key_q, key_d;
  logic [VersionBits-1:0] ver_q, ver_d;

  // Result of the finished lookup, waiting for the output register.
  logic                    res_hit_q, res_hit_d;
  logic [StatusBits-1:0]   res_status_q, res_status_d;
  logic [PAYLOAD_BITS-1:0] res_payload_q, res_payload_d;

  logic                    out_valid_q, out_valid_d;
  logic                    out_hit_q, out_hit_d;
  logic [StatusBits-1:0]   out_status_q, out_status_d;
  logic [PAYLOAD_BITS-1:0] out_payload_q, out_payload_d;

  logic req_fire;
  logic out_free;
  logic key_match;
  logic ver_match;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign ptr_next    = (ptr_q == LastIdx) ? '0 : ptr_q + 1'b1;

  assign key_match = rdata_q.valid && (rdata_q.key == key_q);
  assign ver_match = (rdata_q.version == ver_q);

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.hit         = out_hit_q;
  assign rsp_o.hit_status  = out_status_q;
  assign rsp_o.hit_payload = PayloadWordBits'(out_payload_q);

  always_comb begin
    state_d       = state_q;
    ptr_d         = ptr_q;
    idx_d         = idx_q;
    issue_done_d  = issue_done_q;
    chk_vld_d     = 1'b0;
    chk_addr_d    = chk_addr_q;
    chk_last_d    = chk_last_q;
    key_d         = key_q;
    ver_d         = ver_q;
    res_hit_d     = res_hit_q;
    res_status_d  = res_status_q;
    res_payload_d = res_payload_q;
    out_valid_d   = out_valid_q && !rsp_o.ready;
    out_hit_d     = out_hit_q;
    out_status_d  = out_status_q;
    out_payload_d = out_payload_q;
    rd_en         = 1'b0;
    rd_addr       = idx_q;
    wr_en         = 1'b0;
    wr_addr       = idx_q;
    wr_data       = '0;

    case (state_q)
      ST_CLEAR: begin
        // Writing an all-zero word clears the valid mark of the entry.
        wr_en = 1'b1;
        idx_d = idx_q + 1'b1;
        if (idx_q == LastIdx) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (req_fire) begin
          if (req_i.cmd == CmdStore) begin
            if (req_i.status != StatusUnknown) begin
              // The pointer moves before use, so the first store lands in slot 1.
              wr_en           = 1'b1;
              wr_addr         = ptr_next;
              wr_data.valid   = 1'b1;
              wr_data.key     = req_i.key_hash;
              wr_data.version = req_i.version;
              wr_data.status  = req_i.status;
              wr_data.payload = req_i.payload[PAYLOAD_BITS-1:0];
              ptr_d           = ptr_next;
            end
          end else begin
            key_d        = req_i.key_hash;
            ver_d        = req_i.version;
            idx_d        = '0;
            issue_done_d = 1'b0;
            state_d      = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Issue stage: read the next slot in order.
        if (!issue_done_q) begin
          rd_en        = 1'b1;
          chk_vld_d    = 1'b1;
          chk_addr_d   = idx_q;
          chk_last_d   = (idx_q == LastIdx);
          issue_done_d = (idx_q == LastIdx);
          idx_d        = idx_q + 1'b1;
        end
        // Check stage: the first valid slot with the key decides the answer.
        if (chk_vld_q) begin
          if (key_match) begin
            res_hit_d     = ver_match;
            res_status_d  = ver_match ? rdata_q.status : '0;
            res_payload_d = ver_match ? rdata_q.payload : '0;
            if (!ver_match) begin
              // Stale version: drop the entry.
              wr_en   = 1'b1;
              wr_addr = chk_addr_q;
            end
            chk_vld_d = 1'b0;
            state_d   = ST_RESP;
          end else if (chk_last_q) begin
            res_hit_d     = 1'b0;
            res_status_d  = '0;
            res_payload_d = '0;
            chk_vld_d     = 1'b0;
            state_d       = ST_RESP;
          end
        end
      end

      ST_RESP: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_hit_d     = res_hit_q;
          out_status_d  = res_status_q;
          out_payload_d = res_payload_q;
          state_d       = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      ptr_q        <= '0;
      idx_q        <= '0;
      issue_done_q <= 1'b0;
      chk_vld_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      ptr_q        <= ptr_d;
      idx_q        <= idx_d;
      issue_done_q <= issue_done_d;
      chk_vld_q    <= chk_vld_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    chk_addr_q    <= chk_addr_d;
    chk_last_q    <= chk_last_d;
    key_q         <= key_d;
    ver_q         <= ver_d;
    res_hit_q     <= res_hit_d;
    res_status_q  <= res_status_d;
    res_payload_q <= res_payload_d;
    out_hit_q     <= out_hit_d;
    out_status_q  <= out_status_d;
    out_payload_q <= out_payload_d;
  end

  // Entry memory: synchronous write, read data registered.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

endmodule : versioned_round_robin_cache

`default_nettype wire
